/* rtl/core/esp_pkg.sv */
// Shared types, codes and name tables for the event stream line parser.
// No dependencies; every other file but esp_if.sv imports this package.
package esp_pkg;

    localparam int FIELD_BYTES_DEF = 16;
    localparam int CNT_W           = 5;
    localparam int PLEN_W          = 17;
    localparam int RETRY_W         = 31;

    localparam logic [PLEN_W-1:0]  PLEN_MAX  = 17'h1FFFF;
    localparam logic [RETRY_W-1:0] RETRY_MAX = 31'h7FFFFFFF;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [15:0] EVENT_LIMIT_RST = 16'd4096;

    typedef enum logic [3:0] {
        PH_START   = 4'b0001,
        PH_NAME    = 4'b0010,
        PH_VALUE   = 4'b0100,
        PH_COMMENT = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        F_IDLE  = 3'd0,
        F_DATA  = 3'd1,
        F_EVENT = 3'd2,
        F_ID    = 3'd3,
        F_RETRY = 3'd4,
        F_NONE  = 3'd5
    } field_t;

    typedef enum logic [1:0] {
        K_PAYLOAD  = 2'd0,
        K_DISPATCH = 2'd1,
        K_DROPPED  = 2'd2,
        K_RETRY    = 2'd3
    } kind_t;

    typedef struct packed {
        logic digits;
        logic neg;
        logic bad;
    } retry_flags_t;

    typedef struct packed {
        phase_t              phase;
        field_t              name_match;
        logic [2:0]          name_len;
        logic                after_cr;
        logic                value_started;
        logic                has_payload;
        logic                overflow;
        logic [PLEN_W-1:0]   payload_len;
        logic [CNT_W-1:0]    type_count;
        logic [CNT_W-1:0]    id_count;
        logic                id_valid;
        logic [CNT_W-1:0]    pend_count;
        logic                pend_nul;
        logic [RETRY_W-1:0]  retry_acc;
        retry_flags_t        retry_flags;
    } parse_state_t;

    typedef struct packed {
        kind_t               kind;
        logic [7:0]          payload_byte;
        logic [15:0]         position;
        logic [63:0]         type_low;
        logic [63:0]         type_high;
        logic [4:0]          type_length;
        logic [63:0]         id_low;
        logic [63:0]         id_high;
        logic [4:0]          id_length;
        logic                id_present;
        logic [RETRY_W-1:0]  retry_delay;
    } result_t;

    function automatic logic [2:0] field_len(input field_t f);
        case (f)
            F_DATA:  field_len = 3'd4;
            F_EVENT: field_len = 3'd5;
            F_ID:    field_len = 3'd2;
            F_RETRY: field_len = 3'd5;
            default: field_len = 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] field_char(input field_t f, input logic [2:0] idx);
        logic [39:0] s;
        s = 40'h0;
        case (f)
            F_DATA:  s = {8'h00, "atad"};
            F_EVENT: s = "tneve";
            F_ID:    s = {24'h0, "di"};
            F_RETRY: s = "yrter";
            default: s = 40'h0;
        endcase
        case (idx)
            3'd0:    field_char = s[7:0];
            3'd1:    field_char = s[15:8];
            3'd2:    field_char = s[23:16];
            3'd3:    field_char = s[31:24];
            3'd4:    field_char = s[39:32];
            default: field_char = 8'h00;
        endcase
    endfunction

endpackage

/* rtl/core/esp_if.sv */
// Valid/ready channel interfaces for the parser's byte input and result output.
// Has no package import: the widths are written out and match esp_pkg's result_t.
interface esp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] input_byte;

    modport source (output valid, output input_byte, input ready);
    modport sink   (input valid, input input_byte, output ready);
endinterface

interface esp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] position;
    logic [63:0] type_low;
    logic [63:0] type_high;
    logic [4:0]  type_length;
    logic [63:0] id_low;
    logic [63:0] id_high;
    logic [4:0]  id_length;
    logic        id_present;
    logic [30:0] retry_delay;

    modport source (output valid, output kind, output payload_byte, output position,
                    output type_low, output type_high, output type_length,
                    output id_low, output id_high, output id_length,
                    output id_present, output retry_delay, input ready);
    modport sink   (input valid, input kind, input payload_byte, input position,
                    input type_low, input type_high, input type_length,
                    input id_low, input id_high, input id_length,
                    input id_present, input retry_delay, output ready);
endinterface

/* rtl/core/esp_step.sv */
// Next-state and result logic for one stream byte.
// Depends on esp_pkg.
module esp_step
    import esp_pkg::*;
#(
    parameter int FIELD_BYTES = FIELD_BYTES_DEF
)
(
    input  logic [7:0]   c,
    input  logic [15:0]  event_limit,
    input  parse_state_t st,
    input  logic [7:0]   type_st [FIELD_BYTES],
    input  logic [7:0]   id_st   [FIELD_BYTES],
    input  logic [7:0]   pend_st [FIELD_BYTES],
    output parse_state_t nx,
    output logic [7:0]   type_nx [FIELD_BYTES],
    output logic [7:0]   id_nx   [FIELD_BYTES],
    output logic [7:0]   pend_nx [FIELD_BYTES],
    output logic         res_valid,
    output result_t      res
);

    localparam logic [CNT_W-1:0] FB = CNT_W'(FIELD_BYTES);

    logic [FIELD_BYTES*8-1:0] type_vec;
    logic [FIELD_BYTES*8-1:0] id_vec;
    logic [127:0]             type_wide;
    logic [127:0]             id_wide;
    logic [PLEN_W-1:0]        len_inc;
    logic [34:0]              retry_prod;
    field_t                   full_match;

    always_comb
    begin
        for (int i = 0; i < FIELD_BYTES; i++)
        begin
            type_vec[i*8 +: 8] = type_st[i];
            id_vec[i*8 +: 8]   = id_st[i];
        end
        type_wide = 128'(type_vec);
        id_wide   = 128'(id_vec);
    end

    assign len_inc    = (st.payload_len < PLEN_MAX) ? st.payload_len + 1'b1 : st.payload_len;
    assign retry_prod = {1'b0, st.retry_acc, 3'b000} + {3'b000, st.retry_acc, 1'b0}
                        + 35'(c - CH_ZERO);
    assign full_match = (st.name_match != F_IDLE && st.name_match != F_NONE
                         && st.name_len == field_len(st.name_match))
                        ? st.name_match : F_NONE;

    always_comb
    begin
        nx        = st;
        type_nx   = type_st;
        id_nx     = id_st;
        pend_nx   = pend_st;
        res_valid = 1'b0;
        res       = '0;
        nx.after_cr = 1'b0;

        if (st.after_cr && c == CH_LF)
        begin
            // second half of a CRLF terminator: drop
        end
        else if (c == CH_CR || c == CH_LF)
        begin
            nx.after_cr = (c == CH_CR);
            case (st.phase)
                PH_START:
                begin
                    if (st.overflow)
                    begin
                        res_valid = 1'b1;
                        res.kind  = K_DROPPED;
                    end
                    else if (st.has_payload)
                    begin
                        res_valid       = 1'b1;
                        res.kind        = K_DISPATCH;
                        res.position    = st.payload_len[15:0];
                        res.type_low    = type_wide[63:0];
                        res.type_high   = type_wide[127:64];
                        res.type_length = st.type_count;
                        res.id_low      = id_wide[63:0];
                        res.id_high     = id_wide[127:64];
                        res.id_length   = st.id_count;
                        res.id_present  = st.id_valid;
                    end
                    for (int i = 0; i < FIELD_BYTES; i++)
                        type_nx[i] = 8'h00;
                    nx.type_count  = '0;
                    nx.payload_len = '0;
                    nx.has_payload = 1'b0;
                    nx.overflow    = 1'b0;
                end
                PH_NAME:
                begin
                    case (full_match)
                        F_DATA:
                        begin
                            if (st.has_payload)
                            begin
                                res_valid        = 1'b1;
                                res.kind         = K_PAYLOAD;
                                res.payload_byte = CH_LF;
                                res.position     = st.payload_len[15:0];
                                nx.payload_len   = len_inc;
                                if (len_inc > PLEN_W'(event_limit))
                                    nx.overflow = 1'b1;
                            end
                            nx.has_payload = 1'b1;
                        end
                        F_EVENT:
                        begin
                            for (int i = 0; i < FIELD_BYTES; i++)
                                type_nx[i] = 8'h00;
                            nx.type_count = '0;
                        end
                        F_ID:
                        begin
                            for (int i = 0; i < FIELD_BYTES; i++)
                                id_nx[i] = 8'h00;
                            nx.id_count   = '0;
                            nx.id_valid   = 1'b1;
                            nx.pend_count = '0;
                            nx.pend_nul   = 1'b0;
                        end
                        F_RETRY:
                        begin
                            nx.retry_acc   = '0;
                            nx.retry_flags = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                PH_VALUE:
                begin
                    if (st.name_match == F_ID && !st.pend_nul)
                    begin
                        for (int i = 0; i < FIELD_BYTES; i++)
                            id_nx[i] = (CNT_W'(i) < st.pend_count) ? pend_st[i] : 8'h00;
                        nx.id_count = st.pend_count;
                        nx.id_valid = 1'b1;
                    end
                    else if (st.name_match == F_RETRY && !st.retry_flags.bad
                             && st.retry_flags.digits
                             && (!st.retry_flags.neg || st.retry_acc == '0))
                    begin
                        res_valid       = 1'b1;
                        res.kind        = K_RETRY;
                        res.retry_delay = st.retry_acc;
                    end
                end
                default:
                begin
                end
            endcase
            nx.phase         = PH_START;
            nx.name_match    = F_IDLE;
            nx.name_len      = '0;
            nx.value_started = 1'b0;
        end
        else
        begin
            case (st.phase)
                PH_START:
                begin
                    if (c == CH_COLON)
                        nx.phase = PH_COMMENT;
                    else
                    begin
                        nx.phase      = PH_NAME;
                        nx.name_match = F_NONE;
                        nx.name_len   = '0;
                        if (c == field_char(F_DATA, 3'd0))
                        begin
                            nx.name_match = F_DATA;
                            nx.name_len   = 3'd1;
                        end
                        else if (c == field_char(F_EVENT, 3'd0))
                        begin
                            nx.name_match = F_EVENT;
                            nx.name_len   = 3'd1;
                        end
                        else if (c == field_char(F_ID, 3'd0))
                        begin
                            nx.name_match = F_ID;
                            nx.name_len   = 3'd1;
                        end
                        else if (c == field_char(F_RETRY, 3'd0))
                        begin
                            nx.name_match = F_RETRY;
                            nx.name_len   = 3'd1;
                        end
                    end
                end
                PH_NAME:
                begin
                    if (c == CH_COLON)
                    begin
                        nx.phase         = PH_VALUE;
                        nx.name_match    = full_match;
                        nx.value_started = 1'b0;
                        case (full_match)
                            F_DATA:
                            begin
                                if (st.has_payload)
                                begin
                                    res_valid        = 1'b1;
                                    res.kind         = K_PAYLOAD;
                                    res.payload_byte = CH_LF;
                                    res.position     = st.payload_len[15:0];
                                    nx.payload_len   = len_inc;
                                    if (len_inc > PLEN_W'(event_limit))
                                        nx.overflow = 1'b1;
                                end
                                nx.has_payload = 1'b1;
                            end
                            F_EVENT:
                            begin
                                for (int i = 0; i < FIELD_BYTES; i++)
                                    type_nx[i] = 8'h00;
                                nx.type_count = '0;
                            end
                            F_ID:
                            begin
                                nx.pend_count = '0;
                                nx.pend_nul   = 1'b0;
                            end
                            F_RETRY:
                            begin
                                nx.retry_acc   = '0;
                                nx.retry_flags = '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    else if (st.name_match != F_IDLE && st.name_match != F_NONE)
                    begin
                        if (st.name_len < field_len(st.name_match)
                            && field_char(st.name_match, st.name_len) == c)
                            nx.name_len = st.name_len + 1'b1;
                        else
                            nx.name_match = F_NONE;
                    end
                end
                PH_VALUE:
                begin
                    nx.value_started = 1'b1;
                    if (st.value_started || c != CH_SPACE)
                    begin
                        case (st.name_match)
                            F_DATA:
                            begin
                                res_valid        = 1'b1;
                                res.kind         = K_PAYLOAD;
                                res.payload_byte = c;
                                res.position     = st.payload_len[15:0];
                                nx.payload_len   = len_inc;
                                if (len_inc > PLEN_W'(event_limit))
                                    nx.overflow = 1'b1;
                            end
                            F_EVENT:
                            begin
                                if (st.type_count < FB)
                                begin
                                    for (int i = 0; i < FIELD_BYTES; i++)
                                        if (CNT_W'(i) == st.type_count)
                                            type_nx[i] = c;
                                    nx.type_count = st.type_count + 1'b1;
                                end
                            end
                            F_ID:
                            begin
                                if (c == CH_NUL)
                                    nx.pend_nul = 1'b1;
                                if (st.pend_count < FB)
                                begin
                                    for (int i = 0; i < FIELD_BYTES; i++)
                                        if (CNT_W'(i) == st.pend_count)
                                            pend_nx[i] = c;
                                    nx.pend_count = st.pend_count + 1'b1;
                                end
                            end
                            F_RETRY:
                            begin
                                if (!st.retry_flags.bad)
                                begin
                                    if (c >= CH_ZERO && c <= CH_NINE)
                                    begin
                                        if (retry_prod > 35'(RETRY_MAX))
                                            nx.retry_flags.bad = 1'b1;
                                        else
                                        begin
                                            nx.retry_acc          = retry_prod[RETRY_W-1:0];
                                            nx.retry_flags.digits = 1'b1;
                                        end
                                    end
                                    else if (c == CH_MINUS && !st.retry_flags.digits
                                             && !st.retry_flags.neg)
                                        nx.retry_flags.neg = 1'b1;
                                    else
                                        nx.retry_flags.bad = 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

/* rtl/core/esp_result_reg.sv */
// Output register stage: holds one result until the consumer takes it.
// Depends on esp_pkg and esp_if.
module esp_result_reg
    import esp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  result_t      res,
    output logic         room,
    esp_result_if.source result_out
);

    logic    valid_reg;
    result_t res_reg;

    assign room = !valid_reg || result_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (result_out.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign result_out.valid        = valid_reg;
    assign result_out.kind         = res_reg.kind;
    assign result_out.payload_byte = res_reg.payload_byte;
    assign result_out.position     = res_reg.position;
    assign result_out.type_low     = res_reg.type_low;
    assign result_out.type_high    = res_reg.type_high;
    assign result_out.type_length  = res_reg.type_length;
    assign result_out.id_low       = res_reg.id_low;
    assign result_out.id_high      = res_reg.id_high;
    assign result_out.id_length    = res_reg.id_length;
    assign result_out.id_present   = res_reg.id_present;
    assign result_out.retry_delay  = res_reg.retry_delay;

endmodule

/* rtl/core/event_stream_line_parser.sv */
// Top level of the event stream line parser.
// Depends on esp_pkg, esp_if, esp_step and esp_result_reg.
//
// Takes one raw event-stream byte per transfer and answers with at most one
// result per byte. The parse state sits in a single register bank and the next
// state and result come from one pass of logic, so a byte is accepted in every
// cycle while the result register is empty or being drained in the same cycle.
// Results are registered and appear in the cycle after the byte's transfer.
// Data values stream out as payload bytes (LF joiners included); a blank line
// dispatches an event that holds data with its length, type and last id, or
// reports a drop if the joined payload exceeded the event size limit. Valid
// retry lines report the delay. Write the limit only while the block is idle.
module event_stream_line_parser
    import esp_pkg::*;
#(
    parameter int FIELD_BYTES = FIELD_BYTES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    esp_byte_if.sink     byte_in,
    esp_result_if.source result_out
);

    localparam parse_state_t ST_RESET = '{
        phase:         PH_START,
        name_match:    F_IDLE,
        name_len:      3'd0,
        after_cr:      1'b0,
        value_started: 1'b0,
        has_payload:   1'b0,
        overflow:      1'b0,
        payload_len:   '0,
        type_count:    '0,
        id_count:      '0,
        id_valid:      1'b0,
        pend_count:    '0,
        pend_nul:      1'b0,
        retry_acc:     '0,
        retry_flags:   '0
    };

    parse_state_t st_reg;
    parse_state_t st_next;
    logic [7:0]   type_reg  [FIELD_BYTES];
    logic [7:0]   type_next [FIELD_BYTES];
    logic [7:0]   id_reg    [FIELD_BYTES];
    logic [7:0]   id_next   [FIELD_BYTES];
    logic [7:0]   pend_reg  [FIELD_BYTES];
    logic [7:0]   pend_next [FIELD_BYTES];
    logic [15:0]  event_limit_reg;
    logic         res_valid;
    result_t      res;
    logic         room;
    logic         accept;

    // Take a byte whenever the result register can absorb its result.
    assign byte_in.ready = room;
    assign accept        = byte_in.valid && room;

    esp_step #(
        .FIELD_BYTES (FIELD_BYTES)
    ) u_step (
        .c           (byte_in.input_byte),
        .event_limit (event_limit_reg),
        .st          (st_reg),
        .type_st     (type_reg),
        .id_st       (id_reg),
        .pend_st     (pend_reg),
        .nx          (st_next),
        .type_nx     (type_next),
        .id_nx       (id_next),
        .pend_nx     (pend_next),
        .res_valid   (res_valid),
        .res         (res)
    );

    esp_result_reg u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept && res_valid),
        .res        (res),
        .room       (room),
        .result_out (result_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            event_limit_reg <= EVENT_LIMIT_RST;
        else if (cfg_we)
            event_limit_reg <= cfg_wdata;
    end

    // Advance the parse state and the type and id stores on each byte transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_RESET;
            for (int i = 0; i < FIELD_BYTES; i++)
            begin
                type_reg[i] <= 8'h00;
                id_reg[i]   <= 8'h00;
            end
        end
        else if (accept)
        begin
            st_reg   <= st_next;
            type_reg <= type_next;
            id_reg   <= id_next;
        end
    end

    // Pending id bytes are only read below the pending count: no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
            pend_reg <= pend_next;
    end

endmodule

/* test/event_stream_line_parser_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the event stream line parser: drives byte streams,
// predicts every result in a local parser model and compares each transfer.
// Depends on esp_pkg, esp_if and the event_stream_line_parser RTL.
module event_stream_line_parser_test;
    import esp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [15:0] cfg_wdata;

    esp_byte_if   byte_ch ();
    esp_result_if res_ch ();

    event_stream_line_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .byte_in    (byte_ch.sink),
        .result_out (res_ch.source)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Parser model: its own copy of the line and event state
    // ---------------------------------------------------------------
    typedef enum logic [1:0] {
        LN_START,
        LN_NAME,
        LN_VALUE,
        LN_COMMENT
    } line_pos_t;

    logic [15:0]  m_limit;
    line_pos_t    m_line;
    field_t       m_field;
    int unsigned  m_name_len;
    bit           m_after_cr;
    bit           m_value_seen;
    bit           m_has_data;
    bit           m_too_long;
    int unsigned  m_data_len;
    logic [7:0]   m_type [16];
    int unsigned  m_type_len;
    logic [7:0]   m_id [16];
    int unsigned  m_id_len;
    bit           m_id_set;
    logic [7:0]   m_new_id [16];
    int unsigned  m_new_id_len;
    bit           m_new_id_nul;
    longint unsigned m_retry_val;
    bit           m_retry_digits;
    bit           m_retry_neg;
    bit           m_retry_bad;

    result_t expected_results [$];

    int  mismatches;
    bit  in_flight_done;
    bit  quiet_tail;
    int  idle_cycles;
    int  stall_left;

    function automatic string field_word(field_t f);
        case (f)
            F_DATA:  return "data";
            F_EVENT: return "event";
            F_ID:    return "id";
            F_RETRY: return "retry";
            default: return "";
        endcase
    endfunction

    function automatic result_t blank_result();
        result_t r;
        r = '0;
        return r;
    endfunction

    task automatic queue_payload(input logic [7:0] c);
        result_t r;
        r = blank_result();
        r.kind = K_PAYLOAD;
        r.payload_byte = c;
        r.position = m_data_len[15:0];
        if (m_data_len < 32'h1FFFF) m_data_len++;
        if (m_data_len > m_limit) m_too_long = 1'b1;
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic model_reset();
        m_limit = EVENT_LIMIT_RST;
        m_line = LN_START;
        m_field = F_IDLE;
        m_name_len = 0;
        m_after_cr = 0;
        m_value_seen = 0;
        m_has_data = 0;
        m_too_long = 0;
        m_data_len = 0;
        m_type_len = 0;
        m_id_len = 0;
        m_id_set = 0;
        m_new_id_len = 0;
        m_new_id_nul = 0;
        m_retry_val = 0;
        m_retry_digits = 0;
        m_retry_neg = 0;
        m_retry_bad = 0;
        for (int i = 0; i < 16; i++)
        begin
            m_type[i] = '0;
            m_id[i] = '0;
            m_new_id[i] = '0;
        end
    endtask

    task automatic match_name(input logic [7:0] c);
        string w;
        if (m_field == F_IDLE)
        begin
            m_field = F_NONE;
            for (int k = F_DATA; k <= F_RETRY; k++)
            begin
                w = field_word(field_t'(k));
                if (w[0] == c)
                begin
                    m_field = field_t'(k);
                    m_name_len = 1;
                end
            end
        end
        else if (m_field != F_NONE)
        begin
            w = field_word(m_field);
            if (m_name_len < w.len() && w[m_name_len] == c)
                m_name_len++;
            else
                m_field = F_NONE;
        end
    endtask

    task automatic open_value();
        string w;
        w = field_word(m_field);
        if (m_field == F_IDLE || m_field == F_NONE || m_name_len != w.len())
            m_field = F_NONE;
        m_value_seen = 0;
        case (m_field)
            F_DATA:
            begin
                if (m_has_data) queue_payload(CH_LF);
                m_has_data = 1;
            end
            F_EVENT:
            begin
                for (int i = 0; i < 16; i++) m_type[i] = '0;
                m_type_len = 0;
            end
            F_ID:
            begin
                m_new_id_len = 0;
                m_new_id_nul = 0;
            end
            F_RETRY:
            begin
                m_retry_val = 0;
                m_retry_digits = 0;
                m_retry_neg = 0;
                m_retry_bad = 0;
            end
            default: ;
        endcase
    endtask

    task automatic take_value_byte(input logic [7:0] c);
        longint unsigned v;
        case (m_field)
            F_DATA: queue_payload(c);
            F_EVENT: if (m_type_len < 16) m_type[m_type_len++] = c;
            F_ID:
            begin
                if (c == CH_NUL) m_new_id_nul = 1;
                if (m_new_id_len < 16) m_new_id[m_new_id_len++] = c;
            end
            F_RETRY:
            begin
                if (!m_retry_bad)
                begin
                    if (c >= CH_ZERO && c <= CH_NINE)
                    begin
                        v = m_retry_val * 10 + (c - CH_ZERO);
                        if (v > RETRY_MAX) m_retry_bad = 1;
                        else
                        begin
                            m_retry_val = v;
                            m_retry_digits = 1;
                        end
                    end
                    else if (c == CH_MINUS && !m_retry_digits && !m_retry_neg)
                        m_retry_neg = 1;
                    else
                        m_retry_bad = 1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic close_line();
        result_t r;
        if (m_field == F_ID && !m_new_id_nul)
        begin
            for (int i = 0; i < 16; i++)
                m_id[i] = (i < m_new_id_len) ? m_new_id[i] : 8'h00;
            m_id_len = m_new_id_len;
            m_id_set = 1;
        end
        else if (m_field == F_RETRY && !m_retry_bad && m_retry_digits
                 && (!m_retry_neg || m_retry_val == 0))
        begin
            r = blank_result();
            r.kind = K_RETRY;
            r.retry_delay = m_retry_val[30:0];
            expected_results.insert(expected_results.size(), r);
        end
    endtask

    task automatic dispatch_event();
        result_t r;
        r = blank_result();
        if (m_too_long)
        begin
            r.kind = K_DROPPED;
            expected_results.insert(expected_results.size(), r);
        end
        else if (m_has_data)
        begin
            r.kind = K_DISPATCH;
            r.position = m_data_len[15:0];
            for (int i = 0; i < 8; i++)
            begin
                r.type_low[i*8 +: 8]  = m_type[i];
                r.type_high[i*8 +: 8] = m_type[i+8];
                r.id_low[i*8 +: 8]    = m_id[i];
                r.id_high[i*8 +: 8]   = m_id[i+8];
            end
            r.type_length = m_type_len[4:0];
            r.id_length = m_id_len[4:0];
            r.id_present = m_id_set;
            expected_results.insert(expected_results.size(), r);
        end
        for (int i = 0; i < 16; i++) m_type[i] = '0;
        m_type_len = 0;
        m_data_len = 0;
        m_has_data = 0;
        m_too_long = 0;
    endtask

    // Advance the model by one accepted byte.
    task automatic parse_byte(input logic [7:0] c);
        if (m_after_cr)
        begin
            m_after_cr = 0;
            if (c == CH_LF) return;
        end
        if (c == CH_CR || c == CH_LF)
        begin
            if (c == CH_CR) m_after_cr = 1;
            case (m_line)
                LN_START: dispatch_event();
                LN_NAME:
                begin
                    open_value();
                    close_line();
                end
                LN_VALUE: close_line();
                default: ;
            endcase
            m_line = LN_START;
            m_field = F_IDLE;
            m_name_len = 0;
            m_value_seen = 0;
            return;
        end
        case (m_line)
            LN_START:
                if (c == CH_COLON) m_line = LN_COMMENT;
                else
                begin
                    m_line = LN_NAME;
                    m_field = F_IDLE;
                    m_name_len = 0;
                    match_name(c);
                end
            LN_NAME:
                if (c == CH_COLON)
                begin
                    open_value();
                    m_line = LN_VALUE;
                end
                else
                    match_name(c);
            LN_VALUE:
            begin
                if (!m_value_seen)
                begin
                    m_value_seen = 1;
                    if (c != CH_SPACE) take_value_byte(c);
                end
                else
                    take_value_byte(c);
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------
    // Stimulus: one byte per transfer, random gaps unless in the tail
    // ---------------------------------------------------------------
    // Valid stays high between back-to-back bytes; drop it only for a gap
    // or when the stream pauses in drain.
    task automatic send_byte(input logic [7:0] c);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.input_byte <= c;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        parse_byte(c);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Wait until every predicted result has arrived, plus the output latency.
    task automatic drain();
        byte_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        m_limit = v;
    endtask

    task automatic random_value_text(output string s, input int n);
        s = "";
        for (int i = 0; i < n; i++)
        begin
            byte unsigned b;
            b = $urandom_range(32, 126);
            s = {s, string'(b)};
        end
    endtask

    // Directed: field names, comments, terminators, retry syntax, id with NUL.
    task automatic test_directed();
        send_text("data:hello\n\n");
        send_text(": note\r\nevent: ping\rdata\r\ndata: x\r\n\r\n");
        send_text("id: abcdefghijklmnopqrstu\nretry: 123\n-retry:-0\n");
        send_byte(8'hFF);
        send_byte(8'h00);
        send_text("\nid:a");
        send_byte(CH_NUL);
        send_text("b\nretry:+5\nretry:-7\nretry:99999999999\n");
        send_text("retry\nevent\nid\ndatax:1\nevent:0123456789abcdefXY\ndata:z\n\n\n");
        drain();
    endtask

    task automatic test_limits();
        write_limit(16'd0);
        send_text("data\n\ndata:a\n\n");
        write_limit(16'd3);
        send_text("data:abc\n\ndata:ab\ndata\n\n");
        write_limit(16'hFFFF);
        send_text("data:big\n\n");
        write_limit(16'd40);
    endtask

    // Random: mostly well-formed events with random content, some raw noise.
    task automatic test_random_stream(input int target);
        int sent;
        string v;
        string eol;
        sent = 0;
        while (sent < target)
        begin
            case ($urandom_range(0, 3))
                0: eol = "\r";
                1: eol = "\r\n";
                default: eol = "\n";
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    random_value_text(v, $urandom_range(0, 12));
                    v = {"data:", v, eol};
                end
                4: begin random_value_text(v, $urandom_range(0, 20)); v = {"event: ", v, eol}; end
                5: begin random_value_text(v, $urandom_range(0, 20)); v = {"id:", v, eol}; end
                6: v = {"retry: ", $sformatf("%0d", $urandom_range(0, 100000)), eol};
                7: v = eol;
                8: v = {":c", eol};
                default:
                begin
                    v = "";
                    repeat ($urandom_range(1, 6))
                    begin
                        byte unsigned b;
                        b = $urandom_range(0, 255);
                        v = {v, string'(b)};
                    end
                end
            endcase
            // NUL bytes cannot live in a string; an occasional NUL goes out on its own
            send_text(v);
            if ($urandom_range(0, 19) == 0) send_byte(8'h00);
            sent += v.len();
        end
        send_text("\n\n");
    endtask

    // ---------------------------------------------------------------
    // Result sink: random stall bursts, whole-result compare
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n || quiet_tail)
        begin
            stall_left <= 0;
            res_ch.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 6);
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.kind = kind_t'(res_ch.kind);
            got.payload_byte = res_ch.payload_byte;
            got.position = res_ch.position;
            got.type_low = res_ch.type_low;
            got.type_high = res_ch.type_high;
            got.type_length = res_ch.type_length;
            got.id_low = res_ch.id_low;
            got.id_high = res_ch.id_high;
            got.id_length = res_ch.id_length;
            got.id_present = res_ch.id_present;
            got.retry_delay = res_ch.retry_delay;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %p", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, actual %p", want, got);
                end
            end
        end
    end

    // Hold a watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("event_stream_line_parser_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0;
        idle_cycles = 0;
        quiet_tail = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        byte_ch.valid = 1'b0;
        byte_ch.input_byte = '0;
        res_ch.ready = 1'b1;
        model_reset();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_limits();
        test_random_stream(220);
        write_limit(16'd4096);
        quiet_tail = 1;
        test_random_stream(80);
        drain();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("event_stream_line_parser_test: done, clean");
        else
            $display("event_stream_line_parser_test: done, errors");
        $finish;
    end
endmodule
